>>> src/gray_histogram_normalizer_unit_macros.svh
// Assertion macros shared by the histogram unit.
`ifndef GRAY_HISTOGRAM_NORMALIZER_UNIT_MACROS_SVH
`define GRAY_HISTOGRAM_NORMALIZER_UNIT_MACROS_SVH

// Check a property at each rising clock edge outside reset.
`define GHN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition leads to a result in the next cycle.
`define GHN_ASSERT_NEXT(label, cond, res, msg) \
    `GHN_ASSERT(label, (cond) |=> (res), msg)

`endif

>>> src/ghn_pkg.sv
// Types and constants of the gray histogram normalizer.
package ghn_pkg;

    localparam int OP_W        = 2;
    localparam int PIX_W       = 8;
    localparam int DH_W        = 12;
    localparam int OUT_COUNT_W = 24;
    localparam int BAR_W       = 12;
    localparam int STEP_W      = 4;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 64;
    localparam int M_PAD_W     = M_TDATA_W - 2 * OUT_COUNT_W - BAR_W;

    localparam logic [OP_W-1:0]   OP_ACCUM = 2'd0;
    localparam logic [OP_W-1:0]   OP_READ  = 2'd1;
    localparam logic [OP_W-1:0]   OP_CLEAR = 2'd2;
    localparam logic [DH_W-1:0]   DH_RESET = 12'd400;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(BAR_W - 1);

    typedef struct packed {
        logic capture;
        logic clear;
        logic mem_rd;
        logic rd_sel;
        logic acc_wr;
        logic mul;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_status;

endpackage

>>> src/ghn_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ghn_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/ghn_ctrl.sv
// Controller state machine of the gray histogram normalizer.
module ghn_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    input  logic [ghn_pkg::OP_W-1:0] i_op,
    input  ghn_pkg::t_status         i_status,
    output logic                     o_s_tready,
    output ghn_pkg::t_cmd            o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_ACC_RD = 7'b0000010,
        S_ACC_WR = 7'b0000100,
        S_RD_RD  = 7'b0001000,
        S_RD_MUL = 7'b0010000,
        S_RD_DIV = 7'b0100000,
        S_RD_OUT = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.capture = i_s_tvalid;
                if (i_s_tvalid) begin
                    case (i_op)
                        ghn_pkg::OP_ACCUM: n_state = S_ACC_RD;
                        ghn_pkg::OP_READ:  n_state = S_RD_RD;
                        ghn_pkg::OP_CLEAR: o_cmd.clear = 1'b1;
                        default:           n_state = S_IDLE;
                    endcase
                end
            end
            S_ACC_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_ACC_WR;
            end
            S_ACC_WR: begin
                o_cmd.acc_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_RD_RD: begin
                o_cmd.mem_rd = 1'b1;
                o_cmd.rd_sel = 1'b1;
                n_state      = S_RD_MUL;
            end
            S_RD_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_RD_DIV;
            end
            S_RD_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_RD_OUT;
                end
            end
            S_RD_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> src/ghn_datapath.sv
// Datapath: bin store, peak tracking, scaling divider and output register.
`include "gray_histogram_normalizer_unit_macros.svh"

module ghn_datapath #(
    parameter int BINS       = 256,
    parameter int COUNT_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ghn_pkg::t_cmd                  i_cmd,
    input  logic [ghn_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  logic                           i_cfg_we,
    input  logic [ghn_pkg::DH_W-1:0]       i_cfg_wdata,
    input  logic                           i_m_tready,
    output ghn_pkg::t_status               o_status,
    output logic                           o_m_tvalid,
    output logic [ghn_pkg::M_TDATA_W-1:0]  o_m_tdata
);

    localparam int IW     = $clog2(BINS);
    localparam int PROD_W = COUNT_BITS + ghn_pkg::DH_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [ghn_pkg::PIX_W:0] BINS_LIM = (ghn_pkg::PIX_W + 1)'(BINS);

    logic [ghn_pkg::DH_W-1:0]    r_dh;
    logic [ghn_pkg::PIX_W-1:0]   r_pix;
    logic [ghn_pkg::PIX_W-1:0]   r_idx;
    logic [BINS-1:0]             r_valid;
    logic [COUNT_BITS-1:0]       r_peak;
    logic [COUNT_BITS-1:0]       n_peak;
    logic [COUNT_BITS-1:0]       r_count;
    logic [COUNT_BITS-1:0]       r_rem;
    logic [ghn_pkg::BAR_W-1:0]   r_low;
    logic [ghn_pkg::STEP_W-1:0]  r_step;
    logic                        r_out_valid;
    logic [ghn_pkg::M_TDATA_W-1:0] r_out_data;

    logic                        pix_ok;
    logic                        idx_ok;
    logic [IW-1:0]               mem_raddr;
    logic [COUNT_BITS-1:0]       mem_rdata;
    logic [COUNT_BITS-1:0]       cur_count;
    logic [COUNT_BITS-1:0]       c_new;
    logic                        acc_we;
    logic [PROD_W-1:0]           prod;
    logic [COUNT_BITS:0]         rem_sh;
    logic                        q_bit;
    logic [ghn_pkg::BAR_W-1:0]   bar;

    assign pix_ok    = {1'b0, r_pix} < BINS_LIM;
    assign idx_ok    = {1'b0, r_idx} < BINS_LIM;
    assign mem_raddr = i_cmd.rd_sel ? r_idx[IW-1:0] : r_pix[IW-1:0];
    assign acc_we    = i_cmd.acc_wr && pix_ok;

    always_comb begin
        cur_count = '0;
        if (i_cmd.rd_sel || i_cmd.mul) begin
            if (idx_ok && r_valid[r_idx[IW-1:0]]) begin
                cur_count = mem_rdata;
            end
        end else if (pix_ok && r_valid[r_pix[IW-1:0]]) begin
            cur_count = mem_rdata;
        end
    end

    assign c_new  = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
    assign n_peak = (c_new > r_peak) ? c_new : r_peak;
    assign prod   = PROD_W'(cur_count) * PROD_W'(r_dh);
    assign rem_sh = {r_rem, r_low[ghn_pkg::BAR_W-1]};
    assign q_bit  = rem_sh >= {1'b0, r_peak};
    assign bar    = (r_peak == '0) ? '0 : r_low;

    ghn_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (BINS)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (r_pix[IW-1:0]),
        .i_wdata (c_new),
        .i_re    (i_cmd.mem_rd),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dh        <= ghn_pkg::DH_RESET;
            r_valid     <= '0;
            r_peak      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dh <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_valid <= '0;
                r_peak  <= '0;
            end else if (acc_we) begin
                r_valid[r_pix[IW-1:0]] <= 1'b1;
                r_peak                 <= n_peak;
            end
            if (i_cmd.mul) begin
                r_step <= '0;
            end else if (i_cmd.div_step) begin
                r_step <= r_step + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pix <= i_s_tdata[ghn_pkg::PIX_W-1:0];
            r_idx <= i_s_tdata[2*ghn_pkg::PIX_W-1:ghn_pkg::PIX_W];
        end
        if (i_cmd.mul) begin
            r_count <= cur_count;
            r_rem   <= prod[PROD_W-1:ghn_pkg::BAR_W];
            r_low   <= prod[ghn_pkg::BAR_W-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? COUNT_BITS'(rem_sh - {1'b0, r_peak}) : rem_sh[COUNT_BITS-1:0];
            r_low <= {r_low[ghn_pkg::BAR_W-2:0], q_bit};
        end
        if (i_cmd.out_load) begin
            r_out_data <= {ghn_pkg::M_PAD_W'(0),
                           ghn_pkg::OUT_COUNT_W'(r_peak),
                           bar,
                           ghn_pkg::OUT_COUNT_W'(r_count)};
        end
    end

    assign o_status.div_last = r_step == ghn_pkg::STEP_LAST;
    assign o_status.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid        = r_out_valid;
    assign o_m_tdata         = r_out_data;

    `GHN_ASSERT_NEXT(a_peak_covers_bin, acc_we, r_peak >= $past(c_new), "peak below a bin count")
    `GHN_ASSERT_NEXT(a_clear_empties, i_cmd.clear, r_peak == '0 && r_valid == '0, "clear incomplete")
    `GHN_ASSERT(a_rem_below_peak, i_cmd.div_step |-> (r_peak == '0 || r_rem < r_peak), "remainder overflow")
    `GHN_ASSERT(a_out_no_overwrite, i_cmd.out_load |-> (!r_out_valid || i_m_tready), "result overwritten")

endmodule

>>> src/gray_histogram_normalizer_unit.sv
// Top level of the gray histogram normalizer.
//
//  channel   dir  handshake                      contents
//  s_axis    in   s_axis_tvalid / s_axis_tready  op, pixel, bin_index
//  m_axis    out  m_axis_tvalid / m_axis_tready  bin_count, bar_height, peak_count
//  cfg       in   i_cfg_we                       display_height
//
// An accumulate transaction runs through accept, RAM read and write back.
// A read transaction runs through accept, RAM read, multiply, a 12-step
// restoring divider and the output load, which waits on a pending result.
// A clear transaction completes at accept; per-bin valid bits empty the store at once.
// Reset is synchronous; the store reads as all zeros right after it.
// A pending result stalls only a following read at its output load.
module gray_histogram_normalizer_unit #(
    parameter int BINS       = 256,
    parameter int COUNT_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ghn_pkg::S_TDATA_W-1:0] s_axis_tdata,  // pixel, bin_index
    input  logic [ghn_pkg::OP_W-1:0]      s_axis_tuser,  // op
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ghn_pkg::M_TDATA_W-1:0] m_axis_tdata,  // bin_count, bar_height, peak_count
    input  logic                          i_cfg_we,
    input  logic [ghn_pkg::DH_W-1:0]      i_cfg_wdata
);

    ghn_pkg::t_cmd    cmd;
    ghn_pkg::t_status status;

    ghn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_op       (s_axis_tuser),
        .i_status   (status),
        .o_s_tready (s_axis_tready),
        .o_cmd      (cmd)
    );

    ghn_datapath #(
        .BINS       (BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_s_tdata   (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_tready  (m_axis_tready),
        .o_status    (status),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule
